// ===== hdl/fpsc_pkg.sv =====
// Shared types and constants for the frame pacing skip controller.
`timescale 1ns / 1ps

package fpsc_pkg;

  localparam int unsigned CFG_W     = 32;
  localparam int unsigned CFG_IDX_W = 1;
  localparam int unsigned SKIP_W    = 4;
  localparam int unsigned FRAME_W   = 16;

  localparam logic [CFG_IDX_W-1:0] REG_FRAME_PERIOD  = 1'b0;
  localparam logic [CFG_IDX_W-1:0] REG_TICKS_PER_SEC = 1'b1;

  localparam logic [CFG_W-1:0] FRAME_PERIOD_RST  = 32'd16667;
  localparam logic [CFG_W-1:0] TICKS_PER_SEC_RST = 32'd1000000;

  typedef enum logic [2:0] {
    ST_IDLE,
    ST_EVAL,
    ST_CHK,
    ST_DIV,
    ST_FIN
  } fpsc_state_t;

  typedef struct packed {
    logic latch_in;
    logic arm;
    logic advance;
    logic use_skip;
    logic mark_wait;
    logic div_init;
    logic div_step;
    logic div_finish;
    logic count_frame;
    logic load_out;
  } fpsc_cmd_t;

  typedef struct packed {
    logic first_pending;
    logic skips_nz;
    logic early;
    logic div_done;
  } fpsc_status_t;

endpackage

// ===== hdl/fpsc_ctrl.sv =====
// Control state machine: sequences one request and owns the result beat valid.
`timescale 1ns / 1ps

module fpsc_ctrl (
  input  logic                  clk,
  input  logic                  rst_n,
  input  logic                  in_valid,
  output logic                  in_stall,
  output logic                  out_valid,
  input  logic                  out_stall,
  input  fpsc_pkg::fpsc_status_t sts,
  output fpsc_pkg::fpsc_cmd_t    cmd
);
  import fpsc_pkg::*;

  fpsc_state_t state_r, state_nxt;
  logic        out_valid_r, out_valid_nxt;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= ST_IDLE;
      out_valid_r <= 1'b0;
    end else begin
      state_r     <= state_nxt;
      out_valid_r <= out_valid_nxt;
    end
  end

  always_comb begin
    state_nxt = state_r;
    cmd       = '0;
    in_stall  = 1'b1;
    out_valid_nxt = out_valid_r && out_stall;
    unique case (state_r)
      ST_IDLE: begin
        in_stall = 1'b0;
        if (in_valid) begin
          cmd.latch_in = 1'b1;
          state_nxt    = ST_EVAL;
        end
      end
      ST_EVAL: begin
        if (sts.first_pending) begin
          cmd.arm   = 1'b1;
          state_nxt = ST_FIN;
        end else begin
          cmd.advance = 1'b1;
          state_nxt   = ST_CHK;
        end
      end
      ST_CHK: begin
        priority if (sts.skips_nz) begin
          cmd.use_skip = 1'b1;
          state_nxt    = ST_FIN;
        end else if (sts.early) begin
          cmd.mark_wait   = 1'b1;
          cmd.count_frame = 1'b1;
          state_nxt       = ST_FIN;
        end else begin
          cmd.div_init = 1'b1;
          state_nxt    = ST_DIV;
        end
      end
      ST_DIV: begin
        if (sts.div_done) begin
          cmd.div_finish  = 1'b1;
          cmd.count_frame = 1'b1;
          state_nxt       = ST_FIN;
        end else begin
          cmd.div_step = 1'b1;
        end
      end
      ST_FIN: begin
        if (!out_valid_r || !out_stall) begin
          cmd.load_out  = 1'b1;
          out_valid_nxt = 1'b1;
          state_nxt     = ST_IDLE;
        end
      end
      default: state_nxt = ST_IDLE;
    endcase
  end

  assign out_valid = out_valid_r;

endmodule

// ===== hdl/fpsc_datapath.sv =====
// Datapath: pacing state, config registers, skip quotient loop and result register.
`timescale 1ns / 1ps

module fpsc_datapath #(
  parameter int unsigned MAX_SKIP  = 10,
  parameter int unsigned TIME_BITS = 32
) (
  input  logic                              clk,
  input  logic                              rst_n,
  input  logic                              cfg_we,
  input  logic [fpsc_pkg::CFG_IDX_W-1:0]    cfg_index,
  input  logic [fpsc_pkg::CFG_W-1:0]        cfg_wdata,
  input  logic [31:0]                       in_now_ticks,
  input  fpsc_pkg::fpsc_cmd_t               cmd,
  output fpsc_pkg::fpsc_status_t            sts,
  output logic                              out_skip_frame,
  output logic                              out_must_wait,
  output logic [31:0]                       out_wait_until,
  output logic                              out_rate_valid,
  output logic [fpsc_pkg::FRAME_W-1:0]      out_frames_in_window
);
  import fpsc_pkg::*;

  localparam int unsigned TW = TIME_BITS;
  localparam int unsigned DW = (TW > CFG_W) ? TW : CFG_W;
  localparam int unsigned NW = (TW < 32) ? TW : 32;
  localparam int unsigned QW = $clog2(MAX_SKIP + 2);
  localparam logic [QW-1:0]     Q_CLAMP  = QW'(MAX_SKIP + 1);
  localparam logic [SKIP_W-1:0] SKIP_MAX = SKIP_W'(MAX_SKIP);

  logic [CFG_W-1:0]   period_r, tps_r;
  logic [TW-1:0]      now_r, target_r, window_r, rem_r;
  logic [SKIP_W-1:0]  skips_r;
  logic               first_r;
  logic [FRAME_W-1:0] fcount_r;
  logic [QW-1:0]      q_r;
  logic               res_skip_r, res_wait_r, res_rate_r;
  logic [FRAME_W-1:0] res_frames_r;

  logic [DW-1:0]      period_ext, target_sum;
  logic [TW-1:0]      lag, age;
  logic               rem_ge, win_close;
  logic [FRAME_W-1:0] fcount_inc;

  assign period_ext = DW'(period_r);
  assign target_sum = DW'(target_r) + period_ext;
  assign lag        = now_r - target_r;
  assign age        = now_r - window_r;
  assign rem_ge     = DW'(rem_r) >= period_ext;
  assign win_close  = DW'(age) >= DW'(tps_r);
  assign fcount_inc = (fcount_r == '1) ? fcount_r : fcount_r + FRAME_W'(1);

  assign sts.first_pending = first_r;
  assign sts.skips_nz      = (skips_r != '0);
  assign sts.early         = now_r < target_r;
  assign sts.div_done      = (q_r == Q_CLAMP) || !rem_ge;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      period_r <= FRAME_PERIOD_RST;
      tps_r    <= TICKS_PER_SEC_RST;
    end else if (cfg_we) begin
      unique case (cfg_index)
        REG_FRAME_PERIOD:  period_r <= cfg_wdata;
        REG_TICKS_PER_SEC: tps_r    <= cfg_wdata;
        default: ;
      endcase
    end
  end

  // pacing state
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      first_r  <= 1'b1;
      target_r <= '0;
      skips_r  <= '0;
      window_r <= '0;
      fcount_r <= '0;
    end else begin
      if (cmd.arm) begin
        first_r  <= 1'b0;
        target_r <= now_r;
        fcount_r <= '0;
        window_r <= '0;
      end
      if (cmd.advance) target_r <= TW'(target_sum);
      if (cmd.use_skip) skips_r <= skips_r - SKIP_W'(1);
      if (cmd.div_finish) begin
        if (q_r == Q_CLAMP) begin
          skips_r <= SKIP_MAX;
          first_r <= 1'b1;
        end else begin
          skips_r <= SKIP_W'(q_r);
        end
      end
      if (cmd.count_frame) begin
        if (win_close) begin
          fcount_r <= '0;
          window_r <= now_r;
        end else begin
          fcount_r <= fcount_inc;
        end
      end
    end
  end

  // request, quotient loop and per-request result
  always_ff @(posedge clk) begin
    if (cmd.latch_in) begin
      now_r        <= TW'(in_now_ticks[NW-1:0]);
      res_skip_r   <= 1'b0;
      res_wait_r   <= 1'b0;
      res_rate_r   <= 1'b0;
      res_frames_r <= '0;
    end
    if (cmd.use_skip)  res_skip_r <= 1'b1;
    if (cmd.mark_wait) res_wait_r <= 1'b1;
    if (cmd.count_frame && win_close) begin
      res_rate_r   <= 1'b1;
      res_frames_r <= fcount_inc - FRAME_W'(1);
    end
    if (cmd.div_init) begin
      rem_r <= lag;
      q_r   <= '0;
    end else if (cmd.div_step) begin
      rem_r <= TW'(DW'(rem_r) - period_ext);
      q_r   <= q_r + QW'(1);
    end
  end

  // result beat register
  always_ff @(posedge clk) begin
    if (cmd.load_out) begin
      out_skip_frame       <= res_skip_r;
      out_must_wait        <= res_wait_r;
      out_wait_until       <= 32'(target_r[NW-1:0]);
      out_rate_valid       <= res_rate_r;
      out_frames_in_window <= res_frames_r;
    end
  end

endmodule

// ===== hdl/frame_pacing_skip_controller_unit.sv =====
// Sequence: an accepted request is evaluated; an arming request then goes
//   straight to the result, otherwise the skip quotient loop may run, which
//   subtracts the frame period once per cycle and stops after at most
//   MAX_SKIP + 1 steps. One request is handled at a time; a new request is
//   taken while the previous result beat still waits in the output register.
// Reset: synchronous, active low; arms the pacer and loads default config.
`timescale 1ns / 1ps

module frame_pacing_skip_controller_unit #(
  parameter int unsigned MAX_SKIP  = 10,
  parameter int unsigned TIME_BITS = 32
) (
  input  logic                             clk,
  input  logic                             rst_n,
  input  logic                             cfg_valid,
  output logic                             cfg_ready,
  input  logic [fpsc_pkg::CFG_IDX_W-1:0]   cfg_index,
  input  logic [fpsc_pkg::CFG_W-1:0]       cfg_wdata,
  input  logic                             in_valid,
  output logic                             in_stall,
  input  logic [31:0]                      in_now_ticks,
  output logic                             out_valid,
  input  logic                             out_stall,
  output logic                             out_skip_frame,
  output logic                             out_must_wait,
  output logic [31:0]                      out_wait_until,
  output logic                             out_rate_valid,
  output logic [fpsc_pkg::FRAME_W-1:0]     out_frames_in_window
);
  import fpsc_pkg::*;

  fpsc_cmd_t    cmd;
  fpsc_status_t sts;

  assign cfg_ready = 1'b1;

  fpsc_ctrl u_ctrl (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_valid  (in_valid),
    .in_stall  (in_stall),
    .out_valid (out_valid),
    .out_stall (out_stall),
    .sts       (sts),
    .cmd       (cmd)
  );

  fpsc_datapath #(
    .MAX_SKIP  (MAX_SKIP),
    .TIME_BITS (TIME_BITS)
  ) u_dp (
    .clk                  (clk),
    .rst_n                (rst_n),
    .cfg_we               (cfg_valid && cfg_ready),
    .cfg_index            (cfg_index),
    .cfg_wdata            (cfg_wdata),
    .in_now_ticks         (in_now_ticks),
    .cmd                  (cmd),
    .sts                  (sts),
    .out_skip_frame       (out_skip_frame),
    .out_must_wait        (out_must_wait),
    .out_wait_until       (out_wait_until),
    .out_rate_valid       (out_rate_valid),
    .out_frames_in_window (out_frames_in_window)
  );

endmodule

// ===== hdl/fpsc_checker.sv =====
// Port-level checks for the frame pacing skip controller, bound to the top level.
`timescale 1ns / 1ps

module fpsc_checker (
  input logic                             clk,
  input logic                             rst_n,
  input logic                             cfg_valid,
  input logic                             cfg_ready,
  input logic [fpsc_pkg::CFG_IDX_W-1:0]   cfg_index,
  input logic [fpsc_pkg::CFG_W-1:0]       cfg_wdata,
  input logic                             in_valid,
  input logic                             in_stall,
  input logic [31:0]                      in_now_ticks,
  input logic                             out_valid,
  input logic                             out_stall,
  input logic                             out_skip_frame,
  input logic                             out_must_wait,
  input logic [31:0]                      out_wait_until,
  input logic                             out_rate_valid,
  input logic [fpsc_pkg::FRAME_W-1:0]     out_frames_in_window
);

  // a stalled result beat stays up
  a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && out_stall |=> out_valid)
    else $error("result beat dropped while stalled");

  // one request in flight: stall rises right after an accept
  a_one_inflight: assert property (@(posedge clk) disable iff (!rst_n)
    in_valid && !in_stall |=> in_stall)
    else $error("second request taken while one is in flight");

  a_skip_excl: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && out_skip_frame |-> !out_must_wait && !out_rate_valid)
    else $error("skip beat also reports wait or rate");

  a_frames_zero: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && !out_rate_valid |-> out_frames_in_window == '0)
    else $error("frame count reported without a closed window");

endmodule

bind frame_pacing_skip_controller_unit fpsc_checker u_fpsc_checker (.*);

// ===== tb/sv/frame_pacing_skip_controller_unit_test.sv =====
// Self-checking testbench for the frame pacing skip controller, with a pacing scoreboard.
`timescale 1ns / 1ps

module frame_pacing_skip_controller_unit_test;
  import fpsc_pkg::*;

  localparam int MAX_SKIP    = 10;
  localparam int SETTLE      = 24;
  localparam int STALL_LIMIT = 2000;
  localparam int HOLD_CYCLES = 80;

  typedef struct packed {
    logic         skip;
    logic         hold;
    logic [31:0]  target_at;
    logic         rate_ok;
    logic [15:0]  frames;
  } pacing_result_t;

  class pacing_scoreboard;
    logic [31:0]    period;
    logic [31:0]    window_len;
    bit             arm_pending;
    logic [31:0]    target;
    logic [3:0]     skips;
    logic [31:0]    win_start;
    logic [15:0]    drawn;
    pacing_result_t expected_q[$];
    int             errors;

    function new();
      period      = FRAME_PERIOD_RST;
      window_len  = TICKS_PER_SEC_RST;
      arm_pending = 1'b1;
      target      = '0;
      skips       = '0;
      win_start   = '0;
      drawn       = '0;
      errors      = 0;
    endfunction

    function int pending();
      return expected_q.size();
    endfunction

    function void note_request(logic [31:0] now);
      pacing_result_t r;
      logic [31:0]    lag;
      logic [31:0]    q;
      r = '0;
      if (arm_pending) begin
        arm_pending = 1'b0;
        target      = now;
        drawn       = '0;
        win_start   = '0;
      end else begin
        target = target + period;
        if (skips != 0) begin
          skips  = skips - 1'b1;
          r.skip = 1'b1;
        end else begin
          if (now < target) begin
            r.hold = 1'b1;
          end else begin
            lag = now - target;
            q   = (period != 0) ? lag / period : '1;
            if (q > MAX_SKIP) begin
              skips       = 4'(MAX_SKIP);
              arm_pending = 1'b1;
            end else begin
              skips = q[3:0];
            end
          end
          if (drawn != 16'hFFFF) drawn = drawn + 1'b1;
          if (32'(now - win_start) >= window_len) begin
            r.rate_ok = 1'b1;
            r.frames  = drawn - 1'b1;
            drawn     = '0;
            win_start = now;
          end
        end
      end
      r.target_at = target;
      expected_q.push_back(r);
    endfunction

    function void field_check(string name, logic [31:0] exp_v, logic [31:0] act_v);
      if (act_v !== exp_v) begin
        $display("%0t: %s mismatch, expected %0h, got %0h", $time, name, exp_v, act_v);
        errors++;
      end
    endfunction

    function void check_result(pacing_result_t got);
      pacing_result_t exp_r;
      if (expected_q.size() == 0) begin
        $display("%0t: unexpected result beat, expected none, got %0h", $time, got);
        errors++;
        return;
      end
      exp_r = expected_q.pop_front();
      field_check("skip_frame", exp_r.skip, got.skip);
      field_check("must_wait", exp_r.hold, got.hold);
      field_check("wait_until", exp_r.target_at, got.target_at);
      field_check("rate_valid", exp_r.rate_ok, got.rate_ok);
      field_check("frames_in_window", exp_r.frames, got.frames);
    endfunction
  endclass

  logic                 clk;
  logic                 rst_n;
  logic                 cfg_valid;
  logic                 cfg_ready;
  logic [CFG_IDX_W-1:0] cfg_index;
  logic [CFG_W-1:0]     cfg_wdata;
  logic                 in_valid;
  logic                 in_stall;
  logic [31:0]          in_now_ticks;
  logic                 out_valid;
  logic                 out_stall;
  logic                 out_skip_frame;
  logic                 out_must_wait;
  logic [31:0]          out_wait_until;
  logic                 out_rate_valid;
  logic [FRAME_W-1:0]   out_frames_in_window;

  pacing_scoreboard sb;
  bit               quiet;
  bit               long_hold;

  frame_pacing_skip_controller_unit #(
    .MAX_SKIP (MAX_SKIP),
    .TIME_BITS(32)
  ) u_top (
    .clk                 (clk),
    .rst_n               (rst_n),
    .cfg_valid           (cfg_valid),
    .cfg_ready           (cfg_ready),
    .cfg_index           (cfg_index),
    .cfg_wdata           (cfg_wdata),
    .in_valid            (in_valid),
    .in_stall            (in_stall),
    .in_now_ticks        (in_now_ticks),
    .out_valid           (out_valid),
    .out_stall           (out_stall),
    .out_skip_frame      (out_skip_frame),
    .out_must_wait       (out_must_wait),
    .out_wait_until      (out_wait_until),
    .out_rate_valid      (out_rate_valid),
    .out_frames_in_window(out_frames_in_window)
  );

  initial begin
    clk = 1'b0;
    forever #2 clk = ~clk;
  end

  // receiver: random stall bursts, plus one long hold on request
  initial begin : rx_side
    int n;
    out_stall = 1'b0;
    forever begin
      @(posedge clk);
      if (long_hold) begin
        long_hold = 1'b0;
        out_stall <= 1'b1;
        repeat (HOLD_CYCLES) @(posedge clk);
        out_stall <= 1'b0;
      end else if (!quiet && $urandom_range(0, 5) == 0) begin
        n = $urandom_range(1, 4);
        out_stall <= 1'b1;
        repeat (n) @(posedge clk);
        out_stall <= 1'b0;
      end
    end
  end

  always @(posedge clk) begin
    if (rst_n && out_valid && !out_stall)
      sb.check_result({out_skip_frame, out_must_wait, out_wait_until, out_rate_valid,
                       out_frames_in_window});
  end

  initial begin : watchdog
    int idle;
    idle = 0;
    while (idle < STALL_LIMIT) begin
      @(posedge clk);
      if ((in_valid && !in_stall) || (out_valid && !out_stall) || (cfg_valid && cfg_ready))
        idle = 0;
      else
        idle++;
    end
    $display("DONE: errors detected");
    $finish;
  end

  task automatic send_request(input logic [31:0] now);
    int gap;
    in_valid     <= 1'b1;
    in_now_ticks <= now;
    do @(posedge clk); while (in_stall);
    sb.note_request(now);
    if (!quiet && $urandom_range(0, 4) == 0) begin
      gap = $urandom_range(1, 4);
      in_valid <= 1'b0;
      repeat (gap) @(posedge clk);
    end
  endtask

  task automatic drain();
    in_valid <= 1'b0;
    while (sb.pending() != 0) @(posedge clk);
    repeat (SETTLE) @(posedge clk);
  endtask

  task automatic program_rates(input logic [31:0] period, input logic [31:0] window_len);
    cfg_valid <= 1'b1;
    cfg_index <= REG_FRAME_PERIOD;
    cfg_wdata <= period;
    do @(posedge clk); while (!cfg_ready);
    sb.period = period;
    cfg_index <= REG_TICKS_PER_SEC;
    cfg_wdata <= window_len;
    do @(posedge clk); while (!cfg_ready);
    sb.window_len = window_len;
    cfg_valid <= 1'b0;
    @(posedge clk);
  endtask

  // request time aimed at the next due time: early, on time, lagging, clamped or noise
  function automatic logic [31:0] pick_time();
    logic [31:0] due;
    logic [31:0] span;
    int          mode;
    span = (sb.period == 0) ? 32'd1000 : sb.period;
    due  = sb.target + sb.period;
    mode = $urandom_range(0, 15);
    if (sb.arm_pending) return (mode < 4) ? 32'($urandom) : due + $urandom_range(0, 1000);
    if (sb.skips != 0) return due + $urandom_range(0, span - 1);
    if (mode < 5) return due - $urandom_range(1, span);
    if (mode < 9) return due + $urandom_range(0, span - 1);
    if (mode < 13)
      return due + span * $urandom_range(1, MAX_SKIP) + $urandom_range(0, span - 1);
    if (mode == 13) return due + span * $urandom_range(MAX_SKIP + 1, 3 * MAX_SKIP);
    if (mode == 14) return $urandom;
    return due;
  endfunction

  task automatic run_phase(input logic [31:0] period, input logic [31:0] window_len,
                           input int count, input int pause_at, input int hold_at);
    drain();
    program_rates(period, window_len);
    for (int i = 0; i < count; i++) begin
      if (i == hold_at) long_hold = 1'b1;
      if (i == pause_at) begin
        in_valid <= 1'b0;
        do @(posedge clk); while (sb.pending() != 0);
      end
      send_request(pick_time());
    end
  endtask

  initial begin : stimulus
    sb           = new();
    quiet        = 1'b0;
    long_hold    = 1'b0;
    rst_n        = 1'b0;
    in_valid     = 1'b0;
    in_now_ticks = '0;
    cfg_valid    = 1'b0;
    cfg_index    = REG_FRAME_PERIOD;
    cfg_wdata    = '0;
    repeat (2) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    // directed, reset rates: arm, early, on time, lag, skips, clamp, wrap
    send_request(32'd0);
    send_request(32'd5);
    send_request(2 * FRAME_PERIOD_RST);
    send_request(6 * FRAME_PERIOD_RST + 32'd5);
    repeat (3) send_request($urandom);
    send_request(32'hFFFF_FFF0);
    send_request(32'hFFFF_FFF0);
    repeat (MAX_SKIP) send_request($urandom);
    send_request(32'hFFFF_FFFF);
    drain();

    run_phase(32'd100, 32'd1000, 120, 60, 10);
    run_phase(32'd0, 32'd1000, 15, -1, -1);
    run_phase(32'd1, 32'd1, 60, -1, -1);
    run_phase(32'hFFFF_FFFF, 32'hFFFF_FFFF, 40, 20, -1);
    run_phase($urandom_range(1, 5000), $urandom_range(1, 100000), 110, -1, -1);
    drain();
    quiet = 1'b1;
    run_phase(FRAME_PERIOD_RST, TICKS_PER_SEC_RST, 110, -1, -1);
    drain();

    if (sb.errors == 0 && sb.pending() == 0)
      $display("DONE: 0 errors");
    else
      $display("DONE: errors detected");
    $finish;
  end

endmodule

// ===== sim.f =====
hdl/fpsc_pkg.sv
hdl/fpsc_ctrl.sv
hdl/fpsc_datapath.sv
hdl/frame_pacing_skip_controller_unit.sv
hdl/fpsc_checker.sv
tb/sv/frame_pacing_skip_controller_unit_test.sv
